// ===== sv/lpr_pkg.sv =====
// Shared types and constants for the line point rasterizer.
// Used by lpr_ctrl, lpr_dp, line_point_rasterizer and lpr_checker.
package lpr_pkg;

    localparam int COORD_W         = 7;   // width of every coordinate field
    localparam int COORD_LIMIT_DEF = 63;  // default saturation bound for end points
    localparam int D_W             = COORD_W + 1;  // |delta| with sign bit
    localparam int ERR_W           = COORD_W + 2;  // error term
    localparam int E2_W            = ERR_W + 1;    // doubled error term

    typedef enum logic {
        LPR_IDLE,
        LPR_EMIT
    } t_lpr_state;

    // controller -> datapath
    typedef struct packed {
        logic load;  // capture a new end point and reset the walk to the origin
        logic step;  // advance the walk by one point
    } t_lpr_cmd;

    // datapath -> controller
    typedef struct packed {
        logic at_end;  // current point equals the end point
    } t_lpr_sts;

endpackage

// ===== sv/lpr_ctrl.sv =====
// Controller for the line point rasterizer: idle/emit state machine.
// Depends on lpr_pkg; drives lpr_dp through t_lpr_cmd, reads t_lpr_sts.
module lpr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    input  lpr_pkg::t_lpr_sts i_sts,
    output lpr_pkg::t_lpr_cmd o_cmd
);
    import lpr_pkg::*;

    t_lpr_state r_state;
    t_lpr_state n_state;
    logic       out_take;

    assign out_take = (r_state == LPR_EMIT) && !i_out_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            LPR_IDLE: begin
                if (i_in_valid) begin
                    n_state = LPR_EMIT;
                end
            end
            LPR_EMIT: begin
                if (out_take && i_sts.at_end) begin
                    n_state = LPR_IDLE;
                end
            end
            default: n_state = LPR_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            LPR_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            LPR_EMIT: begin
                o_out_valid = 1'b1;
                // the point on show is consumed; move on unless it was the last
                o_cmd.step  = out_take && !i_sts.at_end;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= LPR_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== sv/lpr_dp.sv =====
// Datapath for the line point rasterizer: end point saturation and the
// Bresenham error walk registers. Depends on lpr_pkg; commanded by lpr_ctrl.
module lpr_dp #(
    parameter int COORD_LIMIT = lpr_pkg::COORD_LIMIT_DEF
) (
    input  logic                                i_clk,
    input  lpr_pkg::t_lpr_cmd                   i_cmd,
    output lpr_pkg::t_lpr_sts                   o_sts,
    input  logic signed [lpr_pkg::COORD_W-1:0]  i_end_x,
    input  logic signed [lpr_pkg::COORD_W-1:0]  i_end_y,
    output logic signed [lpr_pkg::COORD_W-1:0]  o_point_x,
    output logic signed [lpr_pkg::COORD_W-1:0]  o_point_y
);
    import lpr_pkg::*;

    localparam logic signed [COORD_W-1:0] LimP = COORD_W'(COORD_LIMIT);
    localparam logic signed [COORD_W-1:0] LimN = -LimP;

    logic signed [COORD_W-1:0] r_ex, n_ex, r_ey, n_ey;
    logic signed [COORD_W-1:0] r_x, n_x, r_y, n_y;
    logic signed [D_W-1:0]     r_dx, n_dx, r_dy, n_dy;
    logic signed [ERR_W-1:0]   r_err, n_err;
    logic                      r_sx, n_sx, r_sy, n_sy;

    logic signed [COORD_W-1:0] ex_sat, ey_sat;
    logic signed [D_W-1:0]     ld_dx, ld_dy;
    logic signed [ERR_W-1:0]   dx_e, dy_e, ld_err, add_x, add_y;
    logic signed [E2_W-1:0]    e2, dx_e2, dy_e2;
    logic                      go_x, go_y;

    // saturate the end point; this also catches the most negative pattern
    always_comb begin
        if (i_end_x > LimP) begin
            ex_sat = LimP;
        end else if (i_end_x < LimN) begin
            ex_sat = LimN;
        end else begin
            ex_sat = i_end_x;
        end
        if (i_end_y > LimP) begin
            ey_sat = LimP;
        end else if (i_end_y < LimN) begin
            ey_sat = LimN;
        end else begin
            ey_sat = i_end_y;
        end
        ld_dx = {ex_sat[COORD_W-1], ex_sat};
        if (ex_sat < 0) begin
            ld_dx = -ld_dx;
        end
        ld_dy = {ey_sat[COORD_W-1], ey_sat};
        if (ey_sat > 0) begin
            ld_dy = -ld_dy;
        end
        ld_err = {ld_dx[D_W-1], ld_dx} + {ld_dy[D_W-1], ld_dy};
    end

    // one walk step: both tests use the error from before the step
    always_comb begin
        e2    = {r_err, 1'b0};
        dx_e  = {r_dx[D_W-1], r_dx};
        dy_e  = {r_dy[D_W-1], r_dy};
        dx_e2 = {{2{r_dx[D_W-1]}}, r_dx};
        dy_e2 = {{2{r_dy[D_W-1]}}, r_dy};
        go_x  = (e2 >= dy_e2);
        go_y  = (e2 <= dx_e2);
        add_x = go_x ? dy_e : '0;
        add_y = go_y ? dx_e : '0;
    end

    always_comb begin
        n_ex  = r_ex;
        n_ey  = r_ey;
        n_dx  = r_dx;
        n_dy  = r_dy;
        n_sx  = r_sx;
        n_sy  = r_sy;
        n_err = r_err;
        n_x   = r_x;
        n_y   = r_y;
        priority if (i_cmd.load) begin
            n_ex  = ex_sat;
            n_ey  = ey_sat;
            n_dx  = ld_dx;
            n_dy  = ld_dy;
            n_sx  = (ex_sat > 0);
            n_sy  = (ey_sat > 0);
            n_err = ld_err;
            n_x   = '0;
            n_y   = '0;
        end else if (i_cmd.step) begin
            n_err = r_err + add_x + add_y;
            if (go_x) begin
                n_x = r_sx ? r_x + COORD_W'(1) : r_x - COORD_W'(1);
            end
            if (go_y) begin
                n_y = r_sy ? r_y + COORD_W'(1) : r_y - COORD_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ex  <= n_ex;
        r_ey  <= n_ey;
        r_dx  <= n_dx;
        r_dy  <= n_dy;
        r_sx  <= n_sx;
        r_sy  <= n_sy;
        r_err <= n_err;
        r_x   <= n_x;
        r_y   <= n_y;
    end

    assign o_sts.at_end = (r_x == r_ex) && (r_y == r_ey);
    assign o_point_x    = r_x;
    assign o_point_y    = r_y;

endmodule

// ===== sv/line_point_rasterizer.sv =====
// Line point rasterizer: walks the Bresenham line from the origin to one end point.
// The origin appears on the output in the cycle after the end point is taken.
// Throughput: one point per cycle while the output is not stalled; an item is
// max(|x|,|y|)+1 points, and a new end point is taken only once its last point is out.
// Reset (synchronous, active low) returns the controller to idle; datapath holds no reset.
module line_point_rasterizer #(
    parameter int COORD_LIMIT = lpr_pkg::COORD_LIMIT_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [lpr_pkg::COORD_W-1:0]  i_end_x,
    input  logic signed [lpr_pkg::COORD_W-1:0]  i_end_y,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [lpr_pkg::COORD_W-1:0]  o_point_x,
    output logic signed [lpr_pkg::COORD_W-1:0]  o_point_y,
    output logic                                o_last_point
);
    import lpr_pkg::*;

    t_lpr_cmd cmd;
    t_lpr_sts sts;

    lpr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    lpr_dp #(
        .COORD_LIMIT (COORD_LIMIT)
    ) u_dp (
        .i_clk     (i_clk),
        .i_cmd     (cmd),
        .o_sts     (sts),
        .i_end_x   (i_end_x),
        .i_end_y   (i_end_y),
        .o_point_x (o_point_x),
        .o_point_y (o_point_y)
    );

    assign o_last_point = sts.at_end;

endmodule

// ===== sv/lpr_checker.sv =====
// Port-level checks for line_point_rasterizer, attached by the bind below.
// Depends on lpr_pkg for the coordinate width.
module lpr_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                o_in_stall,
    input logic signed [lpr_pkg::COORD_W-1:0]  i_end_x,
    input logic signed [lpr_pkg::COORD_W-1:0]  i_end_y,
    input logic                                o_out_valid,
    input logic                                i_out_stall,
    input logic signed [lpr_pkg::COORD_W-1:0]  o_point_x,
    input logic signed [lpr_pkg::COORD_W-1:0]  o_point_y,
    input logic                                o_last_point
);
    import lpr_pkg::*;

    logic in_beat, out_beat;

    assign in_beat  = i_in_valid && !o_in_stall;
    assign out_beat = o_out_valid && !i_out_stall;

    // no new end point is taken while a line is still going out
    a_one_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |-> !o_out_valid)
        else $error("input open while points pending");

    // every line starts at the origin
    a_origin_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat |=> (o_out_valid && o_point_x == '0 && o_point_y == '0))
        else $error("line did not start at the origin");

    // nothing follows the last point of a line
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_beat && o_last_point) |=> !o_out_valid)
        else $error("point after last point");

    // successive points are neighbours and distinct
    a_unit_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_beat && !o_last_point) |=>
            (o_out_valid
             && (o_point_x == $past(o_point_x)
                 || o_point_x == $past(o_point_x) + COORD_W'(1)
                 || o_point_x == $past(o_point_x) - COORD_W'(1))
             && (o_point_y == $past(o_point_y)
                 || o_point_y == $past(o_point_y) + COORD_W'(1)
                 || o_point_y == $past(o_point_y) - COORD_W'(1))
             && !(o_point_x == $past(o_point_x) && o_point_y == $past(o_point_y))))
        else $error("walk step not a single pixel move");

endmodule

bind line_point_rasterizer lpr_checker u_lpr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .i_end_x      (i_end_x),
    .i_end_y      (i_end_y),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_point_x    (o_point_x),
    .o_point_y    (o_point_y),
    .o_last_point (o_last_point)
);
